### sv/dmfa_pkg.sv
// ----------------------------------------------------------------------------
// dmfa_pkg
// Shared types and constants for the eight-line lfu cache lookup block.
// ----------------------------------------------------------------------------
package dmfa_pkg;

	localparam int WORD_BITS    = 32;
	localparam int BLOCK_WORDS  = 4;
	localparam int ADDRESS_BITS = 8;
	localparam int NUM_LINES    = 8;
	localparam int LINE_BITS    = $clog2(NUM_LINES);
	localparam int OFFS_BITS    = $clog2(BLOCK_WORDS);
	localparam int TAG_BITS     = 6;
	localparam int CNT_BITS     = 16;

	// address fields: direct mapped tag and line, fully associative tag low bit
	localparam int DM_TAG_HI  = 7;
	localparam int DM_TAG_LO  = 5;
	localparam int DM_LINE_HI = 4;
	localparam int DM_LINE_LO = 2;
	localparam int FA_TAG_LO  = 2;

	// queue depth on both sides
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	localparam logic MODE_DM = 1'b0;
	localparam logic MODE_FA = 1'b1;

	typedef logic [BLOCK_WORDS-1:0][WORD_BITS-1:0] blk_t;

	typedef struct packed {
		logic [ADDRESS_BITS-1:0] address;
		logic [WORD_BITS-1:0]    refill_word_0;
		logic [WORD_BITS-1:0]    refill_word_1;
		logic [WORD_BITS-1:0]    refill_word_2;
		logic [WORD_BITS-1:0]    refill_word_3;
	} in_word_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] read_data;
		logic                 was_hit;
		logic                 was_replaced;
		logic [LINE_BITS-1:0] line_used;
	} out_word_t;

	// decoded request as the back end sees it
	typedef struct packed {
		logic                 mode;
		logic [TAG_BITS-1:0]  tag;
		logic [LINE_BITS-1:0] dm_line;
		logic [OFFS_BITS-1:0] offset;
		blk_t                 refill;
	} req_t;

	typedef struct packed {
		logic valid;
		req_t req;
	} fq_t;

	typedef enum logic {
		ST_LOOK,
		ST_UPD
	} bk_state_t;

endpackage

### sv/dm_fa_lfu_cache_lookup.sv
// path: a read reaches the result ports through the input queue, the lookup registers and the result queue
// sequencing: the lookup/update sequencer takes no new read while the result queue is full or
//   before the previous update is done, since a lookup needs the tags and hit counts it leaves
// reset: clears the mode (direct mapped), valid bits, hit counts and both queues;
//   tags and line data are not reset and are read only from valid lines
// ----------------------------------------------------------------------------
// dm_fa_lfu_cache_lookup
// Eight-line cache lookup, direct mapped or fully associative with lfu fill.
// ----------------------------------------------------------------------------
module dm_fa_lfu_cache_lookup (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                push,
	output logic                full,
	input  dmfa_pkg::in_word_t  in_word,
	output logic                empty,
	input  logic                pop,
	output dmfa_pkg::out_word_t out_word
);
	import dmfa_pkg::*;

	fq_t       fq;
	logic      fq_pop;
	logic      oq_full;
	logic      oq_push;
	out_word_t oq_word;

	dmfa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.full      (full),
		.in_word   (in_word),
		.fq        (fq),
		.fq_pop    (fq_pop)
	);

	dmfa_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.fq      (fq),
		.fq_pop  (fq_pop),
		.oq_full (oq_full),
		.oq_push (oq_push),
		.oq_word (oq_word)
	);

	dmfa_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.oq_push  (oq_push),
		.oq_word  (oq_word),
		.oq_full  (oq_full),
		.pop      (pop),
		.empty    (empty),
		.out_word (out_word)
	);

endmodule

### sv/dmfa_front.sv
// ----------------------------------------------------------------------------
// dmfa_front
// Input queue: holds the mode register; decodes the tag per mode, and the line and offset.
// ----------------------------------------------------------------------------
module dmfa_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               push,
	output logic               full,
	input  dmfa_pkg::in_word_t in_word,
	output dmfa_pkg::fq_t      fq,
	input  logic               fq_pop
);
	import dmfa_pkg::*;

	logic                  mode_q;
	req_t                  ent_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q;
	logic [Q_PTR_BITS-1:0] rd_ptr_q;
	logic [Q_CNT_BITS-1:0] cnt_q;
	req_t                  req_new;
	logic                  do_push;
	logic                  do_pop;

	always_comb begin
		req_new.mode = mode_q;
		if (mode_q == MODE_FA) begin
			req_new.tag = in_word.address[ADDRESS_BITS-1:FA_TAG_LO];
		end else begin
			req_new.tag = TAG_BITS'(in_word.address[DM_TAG_HI:DM_TAG_LO]);
		end
		req_new.dm_line = in_word.address[DM_LINE_HI:DM_LINE_LO];
		req_new.offset  = in_word.address[OFFS_BITS-1:0];
		req_new.refill  = {in_word.refill_word_3, in_word.refill_word_2,
			in_word.refill_word_1, in_word.refill_word_0};
	end

	assign full     = (cnt_q == Q_CNT_BITS'(Q_DEPTH));
	assign do_push  = push && !full;
	assign do_pop   = fq_pop && fq.valid;
	assign fq.valid = (cnt_q != '0);
	assign fq.req   = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_DM;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= req_new;
		end
	end

endmodule

### sv/dmfa_back.sv
// ----------------------------------------------------------------------------
// dmfa_back
// Lookup and update sequencer: tag compare, victim pick, fill and hit counts.
// ----------------------------------------------------------------------------
module dmfa_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dmfa_pkg::fq_t       fq,
	output logic                fq_pop,
	input  logic                oq_full,
	output logic                oq_push,
	output dmfa_pkg::out_word_t oq_word
);
	import dmfa_pkg::*;

	localparam int KEY_BITS = CNT_BITS + 1;

	bk_state_t             state_q;
	bk_state_t             state_nxt;

	logic [NUM_LINES-1:0]  valid_q;
	logic [TAG_BITS-1:0]   tag_q [NUM_LINES];
	logic [CNT_BITS-1:0]   cnt_q [NUM_LINES];
	blk_t                  mem [NUM_LINES];

	req_t                  req_s1;
	logic                  hit_s1;
	logic                  repl_s1;
	logic [LINE_BITS-1:0]  line_s1;
	blk_t                  row_s1;

	logic [NUM_LINES-1:0]  match;
	logic                  fa_hit;
	logic [LINE_BITS-1:0]  hit_ln;
	logic                  have_open;
	logic [LINE_BITS-1:0]  open_ln;
	logic [KEY_BITS-1:0]   key_l0 [NUM_LINES];
	logic [KEY_BITS-1:0]   key_l1 [NUM_LINES/2];
	logic [LINE_BITS-1:0]  idx_l1 [NUM_LINES/2];
	logic [KEY_BITS-1:0]   key_l2 [NUM_LINES/4];
	logic [LINE_BITS-1:0]  idx_l2 [NUM_LINES/4];
	logic [LINE_BITS-1:0]  min_ln;
	logic                  lk_hit;
	logic                  lk_repl;
	logic [LINE_BITS-1:0]  lk_ln;
	logic                  start;

	// tag compare and first-match / first-free priority
	always_comb begin
		for (int i = 0; i < NUM_LINES; i++) begin
			match[i] = valid_q[i] && (tag_q[i] == fq.req.tag);
		end
		fa_hit    = |match;
		have_open = !(&valid_q);
		hit_ln    = '0;
		open_ln   = '0;
		for (int i = NUM_LINES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_ln = LINE_BITS'(i);
			end
			if (!valid_q[i]) begin
				open_ln = LINE_BITS'(i);
			end
		end
	end

	// min tree over hit counts, ties go to the lower line
	always_comb begin
		for (int i = 0; i < NUM_LINES; i++) begin
			key_l0[i] = {!valid_q[i], cnt_q[i]};
		end
		for (int j = 0; j < NUM_LINES / 2; j++) begin
			if (key_l0[2*j+1] < key_l0[2*j]) begin
				key_l1[j] = key_l0[2*j+1];
				idx_l1[j] = LINE_BITS'(2*j+1);
			end else begin
				key_l1[j] = key_l0[2*j];
				idx_l1[j] = LINE_BITS'(2*j);
			end
		end
		for (int j = 0; j < NUM_LINES / 4; j++) begin
			if (key_l1[2*j+1] < key_l1[2*j]) begin
				key_l2[j] = key_l1[2*j+1];
				idx_l2[j] = idx_l1[2*j+1];
			end else begin
				key_l2[j] = key_l1[2*j];
				idx_l2[j] = idx_l1[2*j];
			end
		end
		if (key_l2[1] < key_l2[0]) begin
			min_ln = idx_l2[1];
		end else begin
			min_ln = idx_l2[0];
		end
	end

	always_comb begin
		if (fq.req.mode == MODE_FA) begin
			lk_hit  = fa_hit;
			lk_repl = !fa_hit && !have_open;
			if (fa_hit) begin
				lk_ln = hit_ln;
			end else if (have_open) begin
				lk_ln = open_ln;
			end else begin
				lk_ln = min_ln;
			end
		end else begin
			lk_ln   = fq.req.dm_line;
			lk_hit  = match[fq.req.dm_line];
			lk_repl = !lk_hit && valid_q[fq.req.dm_line];
		end
	end

	// next state
	always_comb begin
		case (state_q)
			ST_LOOK: begin
				state_nxt = (fq.valid && !oq_full) ? ST_UPD : ST_LOOK;
			end
			ST_UPD: begin
				state_nxt = ST_LOOK;
			end
			default: begin
				state_nxt = ST_LOOK;
			end
		endcase
	end

	// outputs
	always_comb begin
		start   = 1'b0;
		oq_push = 1'b0;
		case (state_q)
			ST_LOOK: begin
				start = fq.valid && !oq_full;
			end
			ST_UPD: begin
				oq_push = 1'b1;
			end
			default: begin
				start   = 1'b0;
				oq_push = 1'b0;
			end
		endcase
	end

	assign fq_pop = start;

	assign oq_word.read_data    = hit_s1 ? row_s1[req_s1.offset] : req_s1.refill[req_s1.offset];
	assign oq_word.was_hit      = hit_s1;
	assign oq_word.was_replaced = repl_s1;
	assign oq_word.line_used    = line_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOOK;
			valid_q <= '0;
			for (int i = 0; i < NUM_LINES; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			if (oq_push) begin
				if (!hit_s1) begin
					valid_q[line_s1] <= 1'b1;
					cnt_q[line_s1]   <= CNT_BITS'(1);
				end else if (cnt_q[line_s1] != '1) begin
					cnt_q[line_s1] <= cnt_q[line_s1] + 1'b1;
				end
			end
		end
	end

	// lookup results and line read; update writes the fill
	always_ff @(posedge clk) begin
		if (start) begin
			req_s1  <= fq.req;
			hit_s1  <= lk_hit;
			repl_s1 <= lk_repl;
			line_s1 <= lk_ln;
			row_s1  <= mem[lk_ln];
		end
		if (oq_push && !hit_s1) begin
			mem[line_s1]   <= req_s1.refill;
			tag_q[line_s1] <= req_s1.tag;
		end
	end

endmodule

### sv/dmfa_outq.sv
// ----------------------------------------------------------------------------
// dmfa_outq
// Result queue between the update sequencer and the result port.
// ----------------------------------------------------------------------------
module dmfa_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                oq_push,
	input  dmfa_pkg::out_word_t oq_word,
	output logic                oq_full,
	input  logic                pop,
	output logic                empty,
	output dmfa_pkg::out_word_t out_word
);
	import dmfa_pkg::*;

	out_word_t             ent_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q;
	logic [Q_PTR_BITS-1:0] rd_ptr_q;
	logic [Q_CNT_BITS-1:0] cnt_q;
	logic                  do_push;
	logic                  do_pop;

	assign oq_full  = (cnt_q == Q_CNT_BITS'(Q_DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = oq_push && !oq_full;
	assign do_pop   = pop && !empty;
	assign out_word = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= oq_word;
		end
	end

endmodule

### sv/dmfa_chk.sv
// ----------------------------------------------------------------------------
// dmfa_chk
// Port-level checks for the cache lookup block, bound to the top level.
// ----------------------------------------------------------------------------
module dmfa_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                push,
	input logic                full,
	input logic                empty,
	input logic                pop,
	input dmfa_pkg::out_word_t out_word
);
	import dmfa_pkg::*;

	// a hit never overwrites a line
	a_hit_no_repl: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(out_word.was_hit && out_word.was_replaced))
		else $error("hit word flagged as replaced");

	// input queue fills only after taking a word
	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted word");

	// the result queue comes out of reset empty and the input queue not full
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> (empty && !full))
		else $error("queues not empty in reset");

	// a waiting word stays until taken
	a_word_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_word)))
		else $error("result word changed before pop");

endmodule

bind dm_fa_lfu_cache_lookup dmfa_chk u_dmfa_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.out_word (out_word)
);
